@@ src/rgbds_pkg.sv @@
// Shared types and constants of the RGBA8 box downsampler.
package rgbds_pkg;

  localparam int CH_W        = 8;   // one color channel
  localparam int XY_W        = 10;  // output pixel column and row ports
  localparam int STEP_REG_W  = 5;
  localparam int WIDTH_REG_W = 11;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

  // register index codes, taken from paddr[2]
  localparam logic REG_STEP  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] a;
  } pix_t;

  // where one source pixel sits inside its block
  typedef struct packed {
    logic first;    // first pixel of a horizontal run inside a block
    logic load;     // first pixel of the whole block
    logic run_end;  // last pixel of a horizontal run
    logic emit;     // last pixel of the block
    logic done;     // last pixel of the face
  } flags_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] a;
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic            done;
  } res_t;

endpackage

@@ src/rgba8_box_downsampler.sv @@
// Top level of the RGBA8 box downsampler: register port, queues and the two parts.
//
// Takes one square RGBA8 face as a raster-order pixel stream, one source pixel per
// request, and returns the truncated red/green/blue average of every
// step_factor x step_factor block with alpha 255 (step factor 1 passes pixels and
// alpha through). The block sustains one source pixel per clock while the result
// side does not push back; after its last source pixel is taken, a result passes
// the front-to-back queue, the accumulate stage behind the line store read, the
// block sum register, the reciprocal multiply and the result queue. The line store
// holds one 3 x 16-bit sum per output column
// (MAX_DST_WIDTH entries, one write and one registered read a cycle) and needs no
// clearing pass: the first pixel of a block always loads its column. A register
// write restarts the face and must be made with the block idle.
module rgba8_box_downsampler #(
  parameter int MAX_DST_WIDTH = 1024,
  parameter int MAX_STEP = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rgbds_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rgbds_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rgbds_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready,
  input  logic                              push,
  output logic                              full,
  input  logic [rgbds_pkg::CH_W-1:0]        in_red,
  input  logic [rgbds_pkg::CH_W-1:0]        in_green,
  input  logic [rgbds_pkg::CH_W-1:0]        in_blue,
  input  logic [rgbds_pkg::CH_W-1:0]        in_alpha,
  output logic                              empty,
  input  logic                              pop,
  output logic [rgbds_pkg::CH_W-1:0]        out_red,
  output logic [rgbds_pkg::CH_W-1:0]        out_green,
  output logic [rgbds_pkg::CH_W-1:0]        out_blue,
  output logic [rgbds_pkg::CH_W-1:0]        out_alpha,
  output logic [rgbds_pkg::XY_W-1:0]        out_x,
  output logic [rgbds_pkg::XY_W-1:0]        out_y,
  output logic                              out_face_done
);

  import rgbds_pkg::*;

  localparam int STEP_W = $clog2(MAX_STEP + 1);
  localparam int WID_W  = $clog2(MAX_DST_WIDTH + 1);
  localparam int COL_W  = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
  localparam int Q_DEPTH   = 4;
  localparam int RES_DEPTH = 2;

  typedef struct packed {
    pix_t             pix;
    flags_t           flags;
    logic [COL_W-1:0] col;
    logic [XY_W-1:0]  y;
  } q_item_t;

  logic [STEP_REG_W-1:0]  step_r;
  logic [WIDTH_REG_W-1:0] width_r;
  logic [STEP_W-1:0]      step_eff;
  logic [WID_W-1:0]       width_eff;
  logic                   cfg_wr;

  pix_t             in_pix;
  logic             fq_push, fq_full, fq_empty, fq_pop;
  q_item_t          fq_wdata, fq_rdata;
  pix_t             f_pix;
  flags_t           f_flags;
  logic [COL_W-1:0] f_col;
  logic [XY_W-1:0]  f_y;
  logic             res_push, res_full;
  res_t             res_w, res_rd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_REG_W'(1);
      width_r <= WIDTH_REG_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_STEP:  step_r  <= pwdata[STEP_REG_W-1:0];
        REG_WIDTH: width_r <= pwdata[WIDTH_REG_W-1:0];
        default:   step_r  <= step_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STEP:  prdata = CFG_DATA_W'(step_r);
      REG_WIDTH: prdata = CFG_DATA_W'(width_r);
      default:   prdata = '0;
    endcase
  end

  // zero means one, values past the maximum saturate
  always_comb begin
    if (step_r == '0) begin
      step_eff = STEP_W'(1);
    end else if (int'(step_r) > MAX_STEP) begin
      step_eff = STEP_W'(MAX_STEP);
    end else begin
      step_eff = STEP_W'(step_r);
    end
    if (width_r == '0) begin
      width_eff = WID_W'(1);
    end else if (int'(width_r) > MAX_DST_WIDTH) begin
      width_eff = WID_W'(MAX_DST_WIDTH);
    end else begin
      width_eff = WID_W'(width_r);
    end
  end

  assign in_pix.r = in_red;
  assign in_pix.g = in_green;
  assign in_pix.b = in_blue;
  assign in_pix.a = in_alpha;

  rgbds_front #(
    .MAX_DST_WIDTH (MAX_DST_WIDTH),
    .MAX_STEP      (MAX_STEP)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step_eff),
    .width   (width_eff),
    .restart (cfg_wr),
    .push    (push),
    .full    (full),
    .in_pix  (in_pix),
    .q_push  (fq_push),
    .q_full  (fq_full),
    .q_pix   (f_pix),
    .q_flags (f_flags),
    .q_col   (f_col),
    .q_y     (f_y)
  );

  assign fq_wdata.pix   = f_pix;
  assign fq_wdata.flags = f_flags;
  assign fq_wdata.col   = f_col;
  assign fq_wdata.y     = f_y;

  rgbds_fifo #(
    .T     (q_item_t),
    .DEPTH (Q_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  rgbds_back #(
    .MAX_DST_WIDTH (MAX_DST_WIDTH),
    .MAX_STEP      (MAX_STEP)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step_eff),
    .q_empty  (fq_empty),
    .q_pop    (fq_pop),
    .q_pix    (fq_rdata.pix),
    .q_flags  (fq_rdata.flags),
    .q_col    (fq_rdata.col),
    .q_y      (fq_rdata.y),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res_w)
  );

  rgbds_fifo #(
    .T     (res_t),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_w),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rd),
    .empty (empty)
  );

  assign out_red       = res_rd.r;
  assign out_green     = res_rd.g;
  assign out_blue      = res_rd.b;
  assign out_alpha     = res_rd.a;
  assign out_x         = res_rd.x;
  assign out_y         = res_rd.y;
  assign out_face_done = res_rd.done;

endmodule

@@ src/rgbds_fifo.sv @@
// Small register FIFO used between the parts of the downsampler.
module rgbds_fifo #(
  parameter type T = logic [7:0],
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign full  = (cnt_r == (PTR_W + 1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + (PTR_W + 1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/rgbds_front.sv @@
// Front part: accepts source pixels and tags each with its place in the block raster.
module rgbds_front #(
  parameter int MAX_DST_WIDTH = 1024,
  parameter int MAX_STEP = 16,
  localparam int STEP_W = $clog2(MAX_STEP + 1),
  localparam int WID_W  = $clog2(MAX_DST_WIDTH + 1),
  localparam int SUB_W  = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1,
  localparam int COL_W  = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [STEP_W-1:0]     step,
  input  logic [WID_W-1:0]      width,
  input  logic                  restart,
  input  logic                  push,
  output logic                  full,
  input  rgbds_pkg::pix_t       in_pix,
  output logic                  q_push,
  input  logic                  q_full,
  output rgbds_pkg::pix_t       q_pix,
  output rgbds_pkg::flags_t     q_flags,
  output logic [COL_W-1:0]      q_col,
  output logic [rgbds_pkg::XY_W-1:0] q_y
);

  import rgbds_pkg::*;

  logic [COL_W-1:0] block_col_r, block_col_nxt;
  logic [COL_W-1:0] block_row_r, block_row_nxt;
  logic [SUB_W-1:0] sub_col_r, sub_col_nxt;
  logic [SUB_W-1:0] sub_row_r, sub_row_nxt;
  logic [COL_W-1:0] col;
  logic             last_sc, last_sr, last_col, last_brow;
  logic             accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  // clamp a column left over from a wider face
  assign col = (WID_W'(block_col_r) >= width) ? COL_W'(width - WID_W'(1)) : block_col_r;

  assign last_sc   = (STEP_W'(sub_col_r) + STEP_W'(1)) == step;
  assign last_sr   = (STEP_W'(sub_row_r) + STEP_W'(1)) == step;
  assign last_col  = (WID_W'(col) + WID_W'(1)) == width;
  assign last_brow = (WID_W'(block_row_r) + WID_W'(1)) == width;

  assign q_flags.first   = (sub_col_r == '0);
  assign q_flags.load    = (sub_col_r == '0) && (sub_row_r == '0);
  assign q_flags.run_end = last_sc;
  assign q_flags.emit    = last_sc && last_sr;
  assign q_flags.done    = last_sc && last_sr && last_col && last_brow;

  assign q_pix.r = in_pix.r;
  assign q_pix.g = in_pix.g;
  assign q_pix.b = in_pix.b;
  assign q_pix.a = (step == STEP_W'(1)) ? in_pix.a : ALPHA_OPAQUE;
  assign q_col   = col;
  assign q_y     = XY_W'(block_row_r);

  always_comb begin
    block_col_nxt = block_col_r;
    block_row_nxt = block_row_r;
    sub_col_nxt   = sub_col_r;
    sub_row_nxt   = sub_row_r;
    if (restart) begin
      block_col_nxt = '0;
      block_row_nxt = '0;
      sub_col_nxt   = '0;
      sub_row_nxt   = '0;
    end else if (accept) begin
      if (!last_sc) begin
        sub_col_nxt   = sub_col_r + SUB_W'(1);
        block_col_nxt = col;
      end else begin
        sub_col_nxt = '0;
        if (!last_col) begin
          block_col_nxt = col + COL_W'(1);
        end else begin
          block_col_nxt = '0;
          if (!last_sr) begin
            sub_row_nxt = sub_row_r + SUB_W'(1);
          end else begin
            sub_row_nxt   = '0;
            block_row_nxt = last_brow ? '0 : block_row_r + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_col_r <= '0;
      block_row_r <= '0;
      sub_col_r   <= '0;
      sub_row_r   <= '0;
    end else begin
      block_col_r <= block_col_nxt;
      block_row_r <= block_row_nxt;
      sub_col_r   <= sub_col_nxt;
      sub_row_r   <= sub_row_nxt;
    end
  end

endmodule

@@ src/rgbds_back.sv @@
// Back part: column line store, run accumulator, reciprocal divide and result issue.
module rgbds_back #(
  parameter int MAX_DST_WIDTH = 1024,
  parameter int MAX_STEP = 16,
  localparam int STEP_W = $clog2(MAX_STEP + 1),
  localparam int COL_W  = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [STEP_W-1:0]     step,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  rgbds_pkg::pix_t       q_pix,
  input  rgbds_pkg::flags_t     q_flags,
  input  logic [COL_W-1:0]      q_col,
  input  logic [rgbds_pkg::XY_W-1:0] q_y,
  output logic                  res_push,
  input  logic                  res_full,
  output rgbds_pkg::res_t       res
);

  import rgbds_pkg::*;

  localparam int LOG_S  = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 0;
  localparam int SUM_W  = CH_W + 2 * LOG_S;
  localparam int SHIFT  = SUM_W + 2 * LOG_S;
  localparam int RCP_W  = SHIFT + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam int TAB_N  = 2 ** STEP_W;

  // reciprocal of step*step, rounded up, exact for every sum below 2**SUM_W
  logic [RCP_W-1:0] rcp_tab [TAB_N];
  for (genvar g = 0; g < TAB_N; g++) begin : g_rcp
    if (g >= 1 && g <= MAX_STEP) begin : g_used
      localparam logic [63:0] NUM = 64'd1 << SHIFT;
      localparam logic [63:0] DEN = 64'(g * g);
      localparam logic [63:0] RCP = (NUM + DEN - 64'd1) / DEN;
      assign rcp_tab[g] = RCP_W'(RCP);
    end else begin : g_unused
      assign rcp_tab[g] = '0;
    end
  end

  logic [3*SUM_W-1:0] sums_mem [MAX_DST_WIDTH];

  logic                      b_vld_r;
  pix_t                      b_pix_r;
  flags_t                    b_flags_r;
  logic [COL_W-1:0]          b_col_r;
  logic [XY_W-1:0]           b_y_r;
  logic [2:0][SUM_W-1:0]     rd_r;
  logic [2:0][SUM_W-1:0]     acc_r;
  logic [2:0][SUM_W-1:0]     acc_nxt;
  logic [2:0][CH_W-1:0]      b_px;

  logic                      m_vld_r;
  logic [2:0][SUM_W-1:0]     m_sum_r;
  logic [CH_W-1:0]           m_a_r;
  logic [XY_W-1:0]           m_x_r, m_y_r;
  logic                      m_done_r;

  logic                      p_vld_r;
  logic [2:0][PROD_W-1:0]    p_prod_r;
  logic [CH_W-1:0]           p_a_r;
  logic [XY_W-1:0]           p_x_r, p_y_r;
  logic                      p_done_r;

  logic [RCP_W-1:0]          rcp_r;
  logic                      a_go, b_go, m_go, p_go;
  logic                      b_rdy, m_rdy, p_rdy;
  logic                      wr_en;

  assign p_go  = p_vld_r && !res_full;
  assign p_rdy = !p_vld_r || p_go;
  assign m_go  = m_vld_r && p_rdy;
  assign m_rdy = !m_vld_r || m_go;
  assign b_go  = b_vld_r && (!b_flags_r.emit || m_rdy);
  assign b_rdy = !b_vld_r || b_go;
  assign a_go  = !q_empty && b_rdy;
  assign q_pop = a_go;
  assign wr_en = b_go && b_flags_r.run_end;

  assign b_px[0] = b_pix_r.r;
  assign b_px[1] = b_pix_r.g;
  assign b_px[2] = b_pix_r.b;

  // start a block from zero, resume a run from the line store, else keep adding
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (b_flags_r.load) begin
        acc_nxt[ch] = SUM_W'(b_px[ch]);
      end else if (b_flags_r.first) begin
        acc_nxt[ch] = rd_r[ch] + SUM_W'(b_px[ch]);
      end else begin
        acc_nxt[ch] = acc_r[ch] + SUM_W'(b_px[ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sums_mem[b_col_r] <= acc_nxt;
    end
  end

  // forward a write to the same column made in the read cycle
  always_ff @(posedge clk) begin
    if (a_go) begin
      if (wr_en && (b_col_r == q_col)) begin
        rd_r <= acc_nxt;
      end else begin
        rd_r <= sums_mem[q_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
    end else begin
      if (b_rdy) begin
        b_vld_r <= a_go;
      end
      if (m_rdy) begin
        m_vld_r <= b_go && b_flags_r.emit;
      end
      if (p_rdy) begin
        p_vld_r <= m_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    rcp_r <= rcp_tab[step];
    if (a_go) begin
      b_pix_r   <= q_pix;
      b_flags_r <= q_flags;
      b_col_r   <= q_col;
      b_y_r     <= q_y;
    end
    if (b_go) begin
      acc_r <= acc_nxt;
    end
    if (b_go && b_flags_r.emit) begin
      m_sum_r  <= acc_nxt;
      m_a_r    <= b_pix_r.a;
      m_x_r    <= XY_W'(b_col_r);
      m_y_r    <= b_y_r;
      m_done_r <= b_flags_r.done;
    end
    if (m_go) begin
      for (int ch = 0; ch < 3; ch++) begin
        p_prod_r[ch] <= PROD_W'(m_sum_r[ch]) * PROD_W'(rcp_r);
      end
      p_a_r    <= m_a_r;
      p_x_r    <= m_x_r;
      p_y_r    <= m_y_r;
      p_done_r <= m_done_r;
    end
  end

  assign res_push = p_go;
  assign res.r    = p_prod_r[0][SHIFT +: CH_W];
  assign res.g    = p_prod_r[1][SHIFT +: CH_W];
  assign res.b    = p_prod_r[2][SHIFT +: CH_W];
  assign res.a    = p_a_r;
  assign res.x    = p_x_r;
  assign res.y    = p_y_r;
  assign res.done = p_done_r;

  a_emit_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && b_flags_r.emit) |-> b_flags_r.run_end)
    else $error("block end without run end");

  a_load_is_first: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && b_flags_r.load) |-> b_flags_r.first)
    else $error("block start not at run start");

  a_emit_reaches_div: assert property (@(posedge clk) disable iff (!rst_n)
    (b_go && b_flags_r.emit) |=> m_vld_r)
    else $error("block result lost before divide");

  a_prod_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && res_full) |=> (p_vld_r && $stable(p_prod_r)))
    else $error("stalled quotient changed");

endmodule

@@ test/box_average_checker.sv @@
// Checker for the box downsampler: tracks registers, predicts each averaged pixel, compares.
`timescale 1ns / 1ps
module box_average_checker
  import rgbds_pkg::*;
#(
  parameter int MAX_DST_W = 1024,
  parameter int MAX_STEP_F = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  push,
  input  logic                  full,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_alpha,
  input  logic                  pop,
  input  logic                  empty,
  input  logic [CH_W-1:0]       out_red,
  input  logic [CH_W-1:0]       out_green,
  input  logic [CH_W-1:0]       out_blue,
  input  logic [CH_W-1:0]       out_alpha,
  input  logic [XY_W-1:0]       out_x,
  input  logic [XY_W-1:0]       out_y,
  input  logic                  out_face_done,
  output int                    awaited,
  output int                    mismatches
);

  logic [15:0] sum_red   [MAX_DST_W];
  logic [15:0] sum_green [MAX_DST_W];
  logic [15:0] sum_blue  [MAX_DST_W];
  int unsigned block_x, block_y, run_x, run_y;
  logic [STEP_REG_W-1:0]  step_reg;
  logic [WIDTH_REG_W-1:0] width_reg;
  res_t expected_pixels[$];
  res_t want;

  task automatic restart_face();
    block_x = 0;
    block_y = 0;
    run_x = 0;
    run_y = 0;
  endtask

  task automatic average_pixel(input pix_t p);
    int unsigned s, w, c, n;
    res_t e;
    s = (step_reg == 0) ? 1 : step_reg;
    if (s > MAX_STEP_F) s = MAX_STEP_F;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_DST_W) w = MAX_DST_W;
    c = block_x;
    if (c >= w) c = w - 1;
    // first pixel of a block loads its column, the rest add
    if (run_x == 0 && run_y == 0) begin
      sum_red[c]   = 16'(p.r);
      sum_green[c] = 16'(p.g);
      sum_blue[c]  = 16'(p.b);
    end else begin
      sum_red[c]   = sum_red[c] + 16'(p.r);
      sum_green[c] = sum_green[c] + 16'(p.g);
      sum_blue[c]  = sum_blue[c] + 16'(p.b);
    end
    if (run_x + 1 >= s && run_y + 1 >= s) begin
      n = s * s;
      if (s == 1) begin
        e.r = p.r;
        e.g = p.g;
        e.b = p.b;
        e.a = p.a;
      end else begin
        e.r = 8'(sum_red[c] / n);
        e.g = 8'(sum_green[c] / n);
        e.b = 8'(sum_blue[c] / n);
        e.a = ALPHA_OPAQUE;
      end
      e.x = XY_W'(c);
      e.y = XY_W'(block_y);
      e.done = (c + 1 >= w) && (block_y + 1 >= w);
      expected_pixels.push_back(e);
    end
    run_x++;
    if (run_x >= s) begin
      run_x = 0;
      block_x = c + 1;
      if (block_x >= w) begin
        block_x = 0;
        run_y++;
        if (run_y >= s) begin
          run_y = 0;
          block_y++;
          if (block_y >= w) block_y = 0;
        end
      end
    end else begin
      block_x = c;
    end
  endtask

  task automatic check_field(input string name, input logic [XY_W-1:0] exp_val,
                             input logic [XY_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_reg = 1;
      width_reg = 1;
      restart_face();
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_STEP) step_reg = pwdata[STEP_REG_W-1:0];
        else width_reg = pwdata[WIDTH_REG_W-1:0];
        restart_face();
      end
      if (push && !full) average_pixel({in_red, in_green, in_blue, in_alpha});
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("result with none expected: x %0d y %0d", out_x, out_y);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_red", want.r, out_red);
          check_field("out_green", want.g, out_green);
          check_field("out_blue", want.b, out_blue);
          check_field("out_alpha", want.a, out_alpha);
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_face_done", want.done, out_face_done);
        end
      end
    end
    awaited = expected_pixels.size();
  end

endmodule

@@ test/testbench.sv @@
// Testbench top: clock, reset, pixel and register stimulus, and the verdict.
`timescale 1ns / 1ps
module testbench;
  import rgbds_pkg::*;

  localparam int MAX_DST_W = 1024;
  localparam int MAX_STEP_F = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic [CH_W-1:0] in_red = '0;
  logic [CH_W-1:0] in_green = '0;
  logic [CH_W-1:0] in_blue = '0;
  logic [CH_W-1:0] in_alpha = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CH_W-1:0] out_red, out_green, out_blue, out_alpha;
  logic [XY_W-1:0] out_x, out_y;
  logic out_face_done;
  int awaited;
  int mismatches;

  logic hold_request = 1'b0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;

  rgba8_box_downsampler #(.MAX_DST_WIDTH(MAX_DST_W), .MAX_STEP(MAX_STEP_F)) dut (.*);

  box_average_checker #(.MAX_DST_W(MAX_DST_W), .MAX_STEP_F(MAX_STEP_F)) checker_i (.*);

  always #4 clk = ~clk;

  function automatic pix_t random_pixel();
    pix_t p;
    case ($urandom_range(0, 15))
      0: p = '0;
      1: p = '1;
      default: p = pix_t'($urandom);
    endcase
    return p;
  endfunction

  task automatic push_pixel(input pix_t p);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_red <= p.r;
    in_green <= p.g;
    in_blue <= p.b;
    in_alpha <= p.a;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold requests until every result is back and the pipeline has emptied
  task automatic drain();
    push <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned step_val, input int unsigned width_val,
                           input int unsigned count, input bit force_burst);
    int unsigned i;
    drain();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_STEP, step_val);
      write_reg(REG_WIDTH, width_val);
    end else begin
      write_reg(REG_WIDTH, width_val);
      write_reg(REG_STEP, step_val);
    end
    tx_burst = force_burst || ($urandom_range(0, 3) == 0);
    for (i = 0; i < count; i++) push_pixel(random_pixel());
  endtask

  initial begin : result_sink
    int gap, taken;
    bit hold_done;
    taken = 0;
    hold_done = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 32 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      // stall long enough for the block to fill and push back
      if (hold_request && !hold_done) begin
        pop <= 1'b0;
        repeat (600) @(negedge clk);
        hold_done = 1;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned i, kind, step_val, width_val, s, w, wmax, face, count, small_pixels;
    bit wide_done;
    small_pixels = 0;
    wide_done = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: one-by-one face, pixels and alpha pass through
    push_pixel('0);
    push_pixel('1);
    push_pixel({8'h55, 8'hAA, 8'h55, 8'hAA});
    push_pixel({8'hAA, 8'h55, 8'hAA, 8'h55});
    push_pixel({8'd1, 8'd2, 8'd3, 8'd4});
    // zero step and zero width act as one
    drain();
    write_reg(REG_STEP, 0);
    write_reg(REG_WIDTH, 0);
    push_pixel({8'd200, 8'd7, 8'd128, 8'd0});
    push_pixel({8'd9, 8'd254, 8'd1, 8'd77});
    // one full two-by-two face of two-by-two blocks
    drain();
    write_reg(REG_STEP, 2);
    write_reg(REG_WIDTH, 2);
    for (i = 0; i < 16; i++) push_pixel({8'(i * 16), 8'hFF, 8'(255 - i), 8'(i)});

    while (small_pixels < 900) begin
      if (!wide_done && small_pixels >= 450) begin
        // saturated width: a full row plus a few pixels, under a long receiver stall
        wide_done = 1;
        hold_request = 1'b1;
        run_phase(1, 2047, 1030, 1'b1);
      end else begin
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
          step_val = $urandom_range(1, 3);
          width_val = $urandom_range(0, 1) ? 1024 : $urandom_range(1025, 2047);
          count = $urandom_range(1, 40);
        end else begin
          if (kind == 1) step_val = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
          else if (kind <= 3) step_val = $urandom_range(5, 16);
          else step_val = $urandom_range(1, 4);
          s = (step_val == 0) ? 1 : ((step_val > MAX_STEP_F) ? MAX_STEP_F : step_val);
          wmax = (16 / s > 0) ? 16 / s : 1;
          width_val = $urandom_range(0, wmax);
          w = (width_val == 0) ? 1 : width_val;
          face = (w * s) * (w * s);
          case ($urandom_range(0, 3))
            0: count = $urandom_range(1, face);
            1: count = (face > 128) ? face : 2 * face;
            default: count = face;
          endcase
        end
        run_phase(step_val, width_val, count, 1'b0);
        small_pixels += count;
      end
    end

    drain();
    if (mismatches == 0 && awaited == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rgbds_pkg.sv
src/rgbds_fifo.sv
src/rgbds_front.sv
src/rgbds_back.sv
src/rgba8_box_downsampler.sv
test/box_average_checker.sv
test/testbench.sv
